[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked during reset too
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bbal_pkg.sv]
// types, constants and helpers for the bitmap block allocator
// no dependencies
package bbal_pkg;

  // bit map word geometry, fixed by the 5-bit block index field
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED   = 2'd1;
  localparam logic [1:0] STATUS_INVALID     = 2'd2;
  localparam logic [1:0] STATUS_ALREADY_FREE = 2'd3;

  // request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [31:0] POOL_BASE_RESET = 32'd4096;

  // position of the lowest clear bit of a word (isolate, then encode)
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] one;
    logic [BIT_W-1:0]  pos;
    inv = ~w;
    one = inv & (~inv + WORD_W'(1));
    pos = '0;
    for (int j = 0; j < BIT_W; j++) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (i[j]) begin
          pos[j] = pos[j] | one[i];
        end
      end
    end
    return pos;
  endfunction

endpackage

[rtl/bbal_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bbal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bitmap_block_allocator.sv]
// bitmap block allocator: accept 1 word; the result word registers as the last step ends,
//   and the last step waits while an older result word is still stalled.
// allocate: acceptance, then one scan step per map word read (one ram read per word),
//   ending on the first word that holds a free block.
// free: range check, three divide steps, then a ram read-modify-write.
// clear, exhausted, invalid range, unused mode: acceptance, then a single emit step.
// reset: synchronous; map words are marked unwritten, no sweep.
module bitmap_block_allocator
  import bbal_pkg::*;
#(
  parameter int N_BLOCKS   = 32,
  parameter int BLOCK_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,      // pool_base
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // address[31:0]
  input  logic [1:0]  s_tuser,       // mode[1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,       // index[4:0], block_address[36:5],
                                     // avail_count[42:37], zero[47:43]
  output logic [1:0]  m_tuser        // status[1:0]
);

  // geometry
  localparam int NUM_WORDS = (N_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = N_BLOCKS > 1 ? $clog2(N_BLOCKS) : 1;
  localparam int IDXE_W    = WA_W + BIT_W;
  localparam int CNT_W     = $clog2(N_BLOCKS + 1);
  localparam int CNT_X     = CNT_W > 6 ? CNT_W : 6;
  localparam int BS_W      = $clog2(BLOCK_SIZE + 1);
  localparam int REM_BITS  = N_BLOCKS - WORD_W * (NUM_WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_PAD = ~((WORD_W'(1) << REM_BITS) - WORD_W'(1));

  // offset division by reciprocal multiplication
  localparam int SPAN   = N_BLOCKS * BLOCK_SIZE;
  localparam int OFF_W  = $clog2(SPAN) + 1;
  localparam int SHIFT  = OFF_W + $clog2(BLOCK_SIZE);
  localparam int M_W    = OFF_W + 1;
  localparam int PROD_W = OFF_W + M_W;
  localparam int QB_W   = IDX_W + BS_W;
  localparam logic [63:0] RECIP = (64'd1 << SHIFT) / BLOCK_SIZE;
  localparam logic [M_W-1:0]   RECIP_V = RECIP[M_W-1:0];
  localparam logic [BS_W-1:0]  BS_V    = BS_W'(BLOCK_SIZE);
  localparam logic [OFF_W-1:0] BS_OFF  = OFF_W'(BLOCK_SIZE);
  localparam logic [31:0]      SPAN32  = 32'(SPAN);
  localparam logic [31:0]      BS32    = 32'(BLOCK_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_DIV_MUL, S_DIV_BACK, S_DIV_FIX, S_FREE, S_EMIT
  } state_t;

  state_t               state;
  logic [31:0]          pool_base;
  logic [CNT_W-1:0]     count;
  logic [NUM_WORDS-1:0] word_valid;
  logic [WA_W-1:0]      wptr;
  logic [OFF_W-1:0]     req_off;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     q0;
  logic [QB_W-1:0]      qb;
  logic [IDX_W-1:0]     idx;
  logic                 misalign;
  logic [1:0]           pend_status;
  logic [1:0]           out_status;
  logic [BIT_W-1:0]     out_index;
  logic [31:0]          out_addr;
  logic [5:0]           out_count;

  logic [WA_W-1:0]      wptr_next;
  logic [WORD_W-1:0]    ram_q;
  logic [WORD_W-1:0]    word_eff;
  logic [WORD_W-1:0]    search;
  logic                 has_free;
  logic [BIT_W-1:0]     bitpos;
  logic [IDXE_W-1:0]    gidx;
  logic [31:0]          alloc_addr;
  logic [IDXE_W-1:0]    idx_ext;
  logic                 bit_set;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [31:0]          off32;
  logic                 in_range;
  logic [IDX_W-1:0]     q0_c;
  logic [OFF_W-1:0]     rem0;
  logic [OFF_W-1:0]     rem_fix;
  logic [IDX_W-1:0]     q_fix;
  logic [IDXE_W-1:0]    q_fix_ext;
  logic [CNT_W-1:0]     cnt_out_val;
  logic [CNT_X-1:0]     cnt_out_x;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {5'd0, out_count, out_addr, out_index};
  assign m_tuser   = out_status;

  // result register loads on the last step of a request
  assign out_load  = out_free && ((state == S_ALLOC && has_free) ||
                                  state == S_FREE || state == S_EMIT);

  // bit map store, one word per 32 blocks
  bbal_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wptr),
    .wdata(ram_wdata),
    .raddr(wptr_next),
    .rdata(ram_q)
  );

  // word under examination; unwritten words read as all free, pad bits as taken
  assign word_eff = word_valid[wptr] ? ram_q : '0;
  assign search   = word_eff | ((wptr == WA_W'(NUM_WORDS - 1)) ? LAST_PAD : '0);
  assign has_free = ~&search;
  assign bitpos   = lowest_zero(search);
  assign gidx     = {wptr, bitpos};
  assign alloc_addr = pool_base + 32'(gidx) * BS32;

  // block being freed
  assign idx_ext  = IDXE_W'(idx);
  assign bit_set  = word_eff[idx_ext[BIT_W-1:0]];

  // range check on the incoming address
  assign off32    = s_tdata - pool_base;
  assign in_range = (s_tdata != 32'd0) && (s_tdata >= pool_base) && (off32 < SPAN32);

  // quotient estimate and one-step correction
  assign q0_c      = IDX_W'(prod >> SHIFT);
  assign rem0      = req_off - OFF_W'(qb);
  assign rem_fix   = (rem0 >= BS_OFF) ? rem0 - BS_OFF : rem0;
  assign q_fix     = (rem0 >= BS_OFF) ? IDX_W'(q0 + 1'b1) : q0;
  assign q_fix_ext = IDXE_W'(q_fix);

  // read address, write-back and reported count
  always_comb begin
    wptr_next   = wptr;
    ram_we      = 1'b0;
    ram_wdata   = word_eff;
    cnt_out_val = count;
    case (state)
      S_IDLE: begin
        wptr_next = '0;
      end
      S_ALLOC: begin
        cnt_out_val = CNT_W'(count - 1'b1);
        ram_wdata   = word_eff | (WORD_W'(1) << bitpos);
        if (has_free) begin
          ram_we = out_free;
        end else begin
          wptr_next = WA_W'(wptr + 1'b1);
        end
      end
      S_DIV_FIX: begin
        wptr_next = q_fix_ext[IDXE_W-1:BIT_W];
      end
      S_FREE: begin
        ram_wdata = word_eff & ~(WORD_W'(1) << idx_ext[BIT_W-1:0]);
        if (!misalign && bit_set) begin
          ram_we      = out_free;
          cnt_out_val = CNT_W'(count + 1'b1);
        end
      end
      default: begin
        wptr_next = wptr;
      end
    endcase
  end

  assign cnt_out_x = CNT_X'(cnt_out_val);

  // state, map bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      pool_base  <= POOL_BASE_RESET;
      count      <= CNT_W'(N_BLOCKS);
      word_valid <= '0;
      wptr       <= '0;
    end else begin
      wptr <= wptr_next;
      if (cfg_valid) begin
        pool_base <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        word_valid[wptr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              MODE_ALLOC: begin
                if (count == '0) begin
                  pend_status <= STATUS_EXHAUSTED;
                  state       <= S_EMIT;
                end else begin
                  state <= S_ALLOC;
                end
              end
              MODE_FREE: begin
                req_off <= off32[OFF_W-1:0];
                if (in_range) begin
                  state <= S_DIV_MUL;
                end else begin
                  pend_status <= STATUS_INVALID;
                  state       <= S_EMIT;
                end
              end
              MODE_CLEAR: begin
                word_valid  <= '0;
                count       <= CNT_W'(N_BLOCKS);
                pend_status <= STATUS_OK;
                state       <= S_EMIT;
              end
              default: begin
                pend_status <= STATUS_OK;
                state       <= S_EMIT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (has_free && out_free) begin
            out_status <= STATUS_OK;
            out_index  <= bitpos;
            out_addr   <= alloc_addr;
            out_count  <= cnt_out_x[5:0];
            count      <= cnt_out_val;
            state      <= S_IDLE;
          end
        end
        S_DIV_MUL: begin
          prod  <= req_off * RECIP_V;
          state <= S_DIV_BACK;
        end
        S_DIV_BACK: begin
          q0    <= q0_c;
          qb    <= q0_c * BS_V;
          state <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          idx      <= q_fix;
          misalign <= (rem_fix != '0);
          state    <= S_FREE;
        end
        S_FREE: begin
          if (out_free) begin
            out_addr  <= 32'd0;
            out_count <= cnt_out_x[5:0];
            count     <= cnt_out_val;
            state     <= S_IDLE;
            if (misalign) begin
              out_status <= STATUS_INVALID;
              out_index  <= '0;
            end else if (!bit_set) begin
              out_status <= STATUS_ALREADY_FREE;
              out_index  <= idx_ext[BIT_W-1:0];
            end else begin
              out_status <= STATUS_OK;
              out_index  <= idx_ext[BIT_W-1:0];
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_status <= pend_status;
            out_index  <= '0;
            out_addr   <= 32'd0;
            out_count  <= cnt_out_x[5:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bbal_checker.sv]
// port-level assertions for the bitmap block allocator, bound to the top level
// depends on bbal_pkg and assert_macros.svh
`include "assert_macros.svh"

module bbal_checker
  import bbal_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [31:0] cfg_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result word holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // reset drops any pending result
  `ASSERT_CLK(a_rst_idle, clk, rst |=> !m_tvalid, "result valid after reset")

  // exhausted means no index, no address and a zero free count
  `ASSERT_CLK_RST(a_exhausted, clk, rst, m_tvalid && m_tuser == STATUS_EXHAUSTED |-> m_tdata[42:0] == 43'd0, "exhausted result carries data")

  // an invalid address reports no index and no address
  `ASSERT_CLK_RST(a_invalid, clk, rst, m_tvalid && m_tuser == STATUS_INVALID |-> m_tdata[36:0] == 37'd0, "invalid result carries index or address")

endmodule

bind bitmap_block_allocator bbal_checker u_bbal_checker (.*);
